>>> design/stlpq_pkg.sv
// shared types and constants of the stable three-level priority queue
`timescale 1ns / 1ps

package stlpq_pkg;

    // store size and field widths
    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TAG_W    = 16;
    localparam int LVL_W    = 2;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    // lowest priority level; level three folds onto it
    localparam logic [LVL_W-1:0] LVL_LOWEST = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // operation broadcast to every cell in the row
    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [TAG_W-1:0] tag;
        logic [LVL_W-1:0] level;
    } cell_cmd_t;

    // where a cell stands relative to the fill count
    typedef struct packed {
        logic occupied;
        logic tail;
    } cell_pos_t;

endpackage

>>> design/stable_three_level_priority_queue.sv
// top level: request decode, row of queue cells, fill count and result register
`timescale 1ns / 1ps

// Stable priority queue of 16 tagged entries on three levels, 0 the highest.
// An enqueue places the entry behind all waiting entries of equal or higher
// priority, so one level leaves in arrival order; a dequeue returns the head.
// Every request gives one result with a status and the occupancy after it.
// One request is taken per clock: all cells compare against the incoming
// level and shift in the same cycle, and the result sits in an output
// register, so a new request is accepted while the previous result waits as
// long as m_ready is high. Level 3 is treated as level 2. An enqueue into a
// full queue and a dequeue from an empty one change nothing and report full
// or empty.

module stable_three_level_priority_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [stlpq_pkg::TAG_W-1:0]      s_tag,
    input  logic [stlpq_pkg::LVL_W-1:0]      s_level,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [stlpq_pkg::STATUS_W-1:0]   m_status,
    output logic [stlpq_pkg::TAG_W-1:0]      m_served_tag,
    output logic [stlpq_pkg::LVL_W-1:0]      m_served_level,
    output logic [stlpq_pkg::OCC_W-1:0]      m_occupancy
);

    localparam int D = stlpq_pkg::DEPTH;

    logic                           accept;
    logic [stlpq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                           full, empty;
    logic [stlpq_pkg::LVL_W-1:0]    level_clamped;
    stlpq_pkg::cell_cmd_t           cmd;
    stlpq_pkg::status_t             status;

    logic                           m_valid_reg, m_valid_next;
    stlpq_pkg::status_t             status_reg;
    logic [stlpq_pkg::TAG_W-1:0]    served_tag_reg, served_tag_next;
    logic [stlpq_pkg::LVL_W-1:0]    served_level_reg, served_level_next;
    logic [stlpq_pkg::OCC_W-1:0]    occ_reg;

    logic                           gt_w    [D];
    logic [stlpq_pkg::TAG_W-1:0]    tag_w   [D];
    logic [stlpq_pkg::LVL_W-1:0]    level_w [D];

    // handshake: take a request whenever the result slot frees up
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (count_reg == stlpq_pkg::CNT_W'(D));
    assign empty = (count_reg == '0);

    // request decode
    always_comb begin
        level_clamped = (s_level > stlpq_pkg::LVL_LOWEST) ? stlpq_pkg::LVL_LOWEST : s_level;
        cmd.enq   = accept && (s_kind == stlpq_pkg::KIND_ENQ) && !full;
        cmd.deq   = accept && (s_kind == stlpq_pkg::KIND_DEQ) && !empty;
        cmd.tag   = s_tag;
        cmd.level = level_clamped;
    end

    // row of cells, head at index 0
    for (genvar i = 0; i < D; i++) begin : g_cell
        stlpq_pkg::cell_pos_t           pos;
        logic                           l_gt;
        logic [stlpq_pkg::TAG_W-1:0]    l_tag;
        logic [stlpq_pkg::LVL_W-1:0]    l_level;
        logic [stlpq_pkg::TAG_W-1:0]    r_tag;
        logic [stlpq_pkg::LVL_W-1:0]    r_level;

        assign pos.occupied = (stlpq_pkg::CNT_W'(i) < count_reg);
        assign pos.tail     = (stlpq_pkg::CNT_W'(i) == count_reg);

        if (i == 0) begin : g_head
            assign l_gt    = 1'b0;
            assign l_tag   = '0;
            assign l_level = '0;
        end else begin : g_mid
            assign l_gt    = gt_w[i-1];
            assign l_tag   = tag_w[i-1];
            assign l_level = level_w[i-1];
        end

        if (i == D - 1) begin : g_last
            assign r_tag   = tag_w[i];
            assign r_level = level_w[i];
        end else begin : g_inner
            assign r_tag   = tag_w[i+1];
            assign r_level = level_w[i+1];
        end

        stlpq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .pos         (pos),
            .left_gt     (l_gt),
            .left_tag    (l_tag),
            .left_level  (l_level),
            .right_tag   (r_tag),
            .right_level (r_level),
            .gt          (gt_w[i]),
            .tag         (tag_w[i]),
            .level       (level_w[i])
        );
    end

    // fill count and result of the accepted request
    always_comb begin
        count_next        = count_reg;
        served_tag_next   = '0;
        served_level_next = '0;
        if (s_kind == stlpq_pkg::KIND_ENQ) begin
            status = full ? stlpq_pkg::ST_FULL : stlpq_pkg::ST_ENQUEUED;
        end else begin
            status = empty ? stlpq_pkg::ST_EMPTY : stlpq_pkg::ST_SERVED;
        end
        if (cmd.enq) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.deq) begin
            count_next        = count_reg - 1'b1;
            served_tag_next   = tag_w[0];
            served_level_next = level_w[0];
        end
    end

    // output slot valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg       <= status;
            served_tag_reg   <= served_tag_next;
            served_level_reg <= served_level_next;
            occ_reg          <= stlpq_pkg::OCC_W'(count_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_served_tag   = served_tag_reg;
    assign m_served_level = served_level_reg;
    assign m_occupancy    = occ_reg;

endmodule

>>> design/stlpq_cell.sv
// one slot of the sorted shift register: holds an entry and shifts by neighbor
`timescale 1ns / 1ps

module stlpq_cell (
    input  logic                          aclk,
    input  stlpq_pkg::cell_cmd_t          cmd,
    input  stlpq_pkg::cell_pos_t          pos,
    input  logic                          left_gt,
    input  logic [stlpq_pkg::TAG_W-1:0]   left_tag,
    input  logic [stlpq_pkg::LVL_W-1:0]   left_level,
    input  logic [stlpq_pkg::TAG_W-1:0]   right_tag,
    input  logic [stlpq_pkg::LVL_W-1:0]   right_level,
    output logic                          gt,
    output logic [stlpq_pkg::TAG_W-1:0]   tag,
    output logic [stlpq_pkg::LVL_W-1:0]   level
);

    logic [stlpq_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [stlpq_pkg::LVL_W-1:0] level_reg, level_next;

    // entry here has lower priority than the incoming request
    assign gt    = pos.occupied && (level_reg > cmd.level);
    assign tag   = tag_reg;
    assign level = level_reg;

    // insert: shift right from the left neighbor or take the new entry
    // remove: shift left from the right neighbor
    always_comb begin
        tag_next   = tag_reg;
        level_next = level_reg;
        if (cmd.enq && (gt || pos.tail)) begin
            if (left_gt) begin
                tag_next   = left_tag;
                level_next = left_level;
            end else begin
                tag_next   = cmd.tag;
                level_next = cmd.level;
            end
        end else if (cmd.deq) begin
            tag_next   = right_tag;
            level_next = right_level;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg   <= tag_next;
        level_reg <= level_next;
    end

endmodule
